/* hw/rtl/mau_pkg.sv */
package mau_pkg;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_NEG = 3'd2,
    ACT_MUL = 3'd3,
    ACT_DIV = 3'd4,
    ACT_INV = 3'd5,
    ACT_POW = 3'd6,
    ACT_EQU = 3'd7
  } action_t;

  localparam int unsigned OPERAND_BITS = 64;
  localparam logic [63:0] RESET_MODULUS = 64'd998244353;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_STEP,
    OP_RED_FIX,
    OP_SIMPLE,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_MUL_DONE,
    OP_INV_INIT,
    OP_DIV_STEP,
    OP_INV_MUL_INIT,
    OP_INV_UPDATE,
    OP_POW_INIT,
    OP_POW_SHIFT,
    OP_FINISH_INV
  } op_t;

  // multiply destination selection
  typedef enum logic [2:0] {
    MD_RESULT,
    MD_POW_R,
    MD_POW_BASE,
    MD_INV_S,
    MD_DIV_RES
  } mdst_t;

  typedef struct packed {
    op_t   op;
    mdst_t mdst;
    logic  red_b;
  } cmd_t;

  typedef struct packed {
    logic red_done;
    logic mul_done;
    logic div_done;
    logic euclid_done;
    logic exp_zero;
    logic exp_lsb;
    logic exp_neg;
    logic mod_small;
    action_t action;
  } status_t;

endpackage

/* hw/rtl/mau_if.sv */
interface mau_in_if;
  logic valid;
  logic ready;
  logic [2:0] action;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;
  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

interface mau_out_if #(parameter int VALUE_BITS = 62);
  logic valid;
  logic ready;
  logic [VALUE_BITS-1:0] result;
  logic not_invertible;
  modport source (output valid, result, not_invertible, input ready);
  modport sink (input valid, result, not_invertible, output ready);
endinterface

/* hw/rtl/modular_arithmetic_unit_core.sv */
// both operands are reduced first; add/sub/neg/equal finish right there,
// mul adds a bit-serial multiply, inverse a serial divide and a multiply per
// euclid round, power a squaring per exponent bit plus a multiply where the
// bit is set; one beat in flight, so a new beat is taken only after the last result is accepted
// rst (synchronous) clears control and sets the modulus to 998244353
module modular_arithmetic_unit_core #(
  parameter int VALUE_BITS = 62
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [VALUE_BITS-1:0] cfg_data,
  mau_in_if.sink                in_ch,
  mau_out_if.source             out_ch
);
  logic [VALUE_BITS-1:0] modulus;
  mau_pkg::cmd_t cmd;
  mau_pkg::status_t status;
  logic load;
  logic [VALUE_BITS-1:0] res;
  logic bad;

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) modulus <= VALUE_BITS'(mau_pkg::RESET_MODULUS);
    else if (cfg_we) modulus <= cfg_data;
  end

  mau_control u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .load, .status, .cmd
  );

  mau_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .m(modulus), .load,
    .in_action(in_ch.action), .in_a(in_ch.operand_a), .in_b(in_ch.operand_b),
    .cmd, .status, .res, .bad
  );

  assign out_ch.result = status.mod_small ? '0 : res;
  assign out_ch.not_invertible = status.mod_small ? 1'b0 : bad;
endmodule

/* hw/rtl/mau_datapath.sv */
module mau_datapath #(
  parameter int VALUE_BITS = 62
) (
  input  logic                  clk,
  input  logic [VALUE_BITS-1:0] m,
  input  logic                  load,
  input  logic [2:0]            in_action,
  input  logic [63:0]           in_a,
  input  logic [63:0]           in_b,
  input  mau_pkg::cmd_t         cmd,
  output mau_pkg::status_t      status,
  output logic [VALUE_BITS-1:0] res,
  output logic                  bad
);
  localparam int W = VALUE_BITS;
  localparam int CW = $clog2(W + 65);

  logic [2:0] action;
  logic [63:0] raw_a, raw_b, expo;
  logic [W-1:0] a, b;
  // restoring reduction of a 64-bit magnitude
  logic [63:0] red_q;
  logic [W:0] red_r;
  logic [6:0] red_cnt;
  logic red_neg;
  // bit-serial multiply
  logic [W-1:0] mx, my, macc;
  logic [CW-1:0] mcnt;
  // euclid: divider and coefficient
  logic [W-1:0] ea, eb, s_old, s_cur, quo, rem;
  logic [W:0] dr;
  logic [CW-1:0] dcnt;
  logic [W-1:0] pr, pb;

  logic [W:0] red_sh, red_sub;
  logic [W:0] dsh, dsub;
  logic [W:0] m2, m2s, ma, mas;
  logic [W-1:0] mdbl, madd;
  logic [W:0] sa, ss;

  always_comb begin
    red_sh  = {red_r[W-1:0], red_q[63]};
    red_sub = red_sh - {1'b0, m};
    dsh     = {dr[W-1:0], quo[W-1]};
    dsub    = dsh - {1'b0, eb};
    m2      = {macc, 1'b0};
    m2s     = m2 - {1'b0, m};
    mdbl    = m2s[W] ? macc << 1 : m2s[W-1:0];
    ma      = {1'b0, mdbl} + {1'b0, mx};
    mas     = ma - {1'b0, m};
    madd    = mas[W] ? ma[W-1:0] : mas[W-1:0];
    sa      = {1'b0, a} + {1'b0, b};
    ss      = {1'b0, a} - {1'b0, b};
  end

  always_comb begin
    status.red_done    = (red_cnt == 7'd64);
    status.mul_done    = (mcnt == CW'(W));
    status.div_done    = (dcnt == CW'(W));
    status.euclid_done = (eb == '0);
    status.exp_zero    = (expo == '0);
    status.exp_lsb     = expo[0];
    status.exp_neg     = raw_b[63];
    status.mod_small   = (m < W'(2));
    status.action      = mau_pkg::action_t'(action);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      action <= in_action;
      raw_a <= in_a;
      raw_b <= in_b;
      bad <= 1'b0;
    end else begin
      unique case (cmd.op)
        mau_pkg::OP_LOAD: begin
          red_neg <= cmd.red_b ? raw_b[63] : raw_a[63];
          red_q <= cmd.red_b ? (raw_b[63] ? -raw_b : raw_b)
                             : (raw_a[63] ? -raw_a : raw_a);
          red_r <= '0;
          red_cnt <= '0;
        end
        mau_pkg::OP_RED_STEP: begin
          red_q <= {red_q[62:0], 1'b0};
          red_r <= red_sub[W] ? red_sh : red_sub;
          red_cnt <= red_cnt + 7'd1;
        end
        mau_pkg::OP_RED_FIX: begin
          if (cmd.red_b)
            b <= (red_neg && red_r != '0) ? m - red_r[W-1:0] : red_r[W-1:0];
          else
            a <= (red_neg && red_r != '0) ? m - red_r[W-1:0] : red_r[W-1:0];
        end
        mau_pkg::OP_SIMPLE: begin
          unique case (mau_pkg::action_t'(action))
            mau_pkg::ACT_ADD: res <= (sa >= {1'b0, m}) ? W'(sa - {1'b0, m}) : sa[W-1:0];
            mau_pkg::ACT_SUB: res <= ss[W] ? W'(ss + {1'b0, m}) : ss[W-1:0];
            mau_pkg::ACT_NEG: res <= (a == '0) ? '0 : m - a;
            default: res <= (a == b) ? W'(1) : '0;
          endcase
        end
        mau_pkg::OP_MUL_INIT: begin
          macc <= '0;
          mcnt <= '0;
          unique case (cmd.mdst)
            mau_pkg::MD_RESULT:   begin mx <= a; my <= b; end
            mau_pkg::MD_POW_R:    begin mx <= pr; my <= pb; end
            mau_pkg::MD_POW_BASE: begin mx <= pb; my <= pb; end
            mau_pkg::MD_DIV_RES:  begin mx <= a; my <= s_old; end
            default:              begin mx <= s_cur; my <= quo; end
          endcase
        end
        mau_pkg::OP_MUL_STEP: begin
          macc <= my[W-1] ? madd : mdbl;
          my <= my << 1;
          mcnt <= mcnt + CW'(1);
        end
        mau_pkg::OP_MUL_DONE: begin
          unique case (cmd.mdst)
            mau_pkg::MD_RESULT:   res <= macc;
            mau_pkg::MD_POW_R:    pr <= macc;
            mau_pkg::MD_POW_BASE: pb <= macc;
            mau_pkg::MD_DIV_RES:  res <= macc;
            default: begin
              // s_next = s_old - q*s_cur mod m
              s_old <= s_cur;
              s_cur <= (s_old >= macc) ? s_old - macc : s_old + (m - macc);
            end
          endcase
        end
        mau_pkg::OP_INV_INIT: begin
          ea <= cmd.red_b ? b : a;
          eb <= m;
          s_old <= W'(1);
          s_cur <= '0;
          dcnt <= '0;
        end
        mau_pkg::OP_DIV_STEP: begin
          if (dcnt == '0) begin
            quo <= ea;
            dr <= '0;
            dcnt <= CW'(1);
          end else begin
            quo <= {quo[W-2:0], ~dsub[W]};
            dr <= dsub[W] ? dsh : dsub;
            dcnt <= dcnt + CW'(1);
          end
        end
        mau_pkg::OP_INV_MUL_INIT: begin
          // final divider bit, then q mod m (q < 2m so one subtract)
          rem <= dsub[W] ? dsh[W-1:0] : dsub[W-1:0];
          quo <= {quo[W-2:0], ~dsub[W]};
          dcnt <= '0;
        end
        mau_pkg::OP_INV_UPDATE: begin
          ea <= eb;
          eb <= rem;
          quo <= (quo >= m) ? quo - m : quo;
        end
        mau_pkg::OP_FINISH_INV: begin
          bad <= (ea != W'(1));
          if (action == 3'(mau_pkg::ACT_INV)) res <= s_old;
          else pb <= s_old;
        end
        mau_pkg::OP_POW_INIT: begin
          pr <= W'(1);
          res <= W'(1);
          if (!raw_b[63]) pb <= a;
          expo <= raw_b[63] ? -raw_b : raw_b;
        end
        mau_pkg::OP_POW_SHIFT: begin
          expo <= expo >> 1;
          res <= pr;
        end
        default: begin
          if (cmd.op == mau_pkg::OP_NONE && status.mod_small) res <= '0;
        end
      endcase
    end
  end
endmodule

/* hw/rtl/mau_control.sv */
module mau_control (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             load,
  input  mau_pkg::status_t status,
  output mau_pkg::cmd_t    cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_RA, S_RAS, S_RAF, S_RB, S_RBS, S_RBF, S_DISP,
    S_MI, S_MS, S_MD, S_II, S_DS, S_DE, S_UPD, S_QI, S_QS, S_QD, S_IF,
    S_PI, S_PT, S_PS, S_OUT
  } state_t;

  state_t state;
  mau_pkg::mdst_t mdst;
  logic qmul;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign load = in_valid && in_ready;

  always_comb begin
    cmd.op = mau_pkg::OP_NONE;
    cmd.mdst = mdst;
    cmd.red_b = 1'b0;
    unique case (state)
      S_RA:  cmd.op = mau_pkg::OP_LOAD;
      S_RAS: cmd.op = status.red_done ? mau_pkg::OP_NONE : mau_pkg::OP_RED_STEP;
      S_RAF: cmd.op = mau_pkg::OP_RED_FIX;
      S_RB:  begin cmd.op = mau_pkg::OP_LOAD; cmd.red_b = 1'b1; end
      S_RBS: begin
        cmd.op = status.red_done ? mau_pkg::OP_NONE : mau_pkg::OP_RED_STEP;
        cmd.red_b = 1'b1;
      end
      S_RBF: begin cmd.op = mau_pkg::OP_RED_FIX; cmd.red_b = 1'b1; end
      S_MI, S_QI: cmd.op = mau_pkg::OP_MUL_INIT;
      S_MS, S_QS: cmd.op = status.mul_done ? mau_pkg::OP_NONE : mau_pkg::OP_MUL_STEP;
      S_MD, S_QD: cmd.op = mau_pkg::OP_MUL_DONE;
      S_II:  begin
        cmd.op = mau_pkg::OP_INV_INIT;
        cmd.red_b = (status.action == mau_pkg::ACT_DIV);
      end
      S_DS:  cmd.op = status.div_done ? mau_pkg::OP_NONE : mau_pkg::OP_DIV_STEP;
      S_DE:  cmd.op = mau_pkg::OP_INV_MUL_INIT;
      S_UPD: cmd.op = mau_pkg::OP_INV_UPDATE;
      S_IF:  cmd.op = mau_pkg::OP_FINISH_INV;
      S_PI:  cmd.op = mau_pkg::OP_POW_INIT;
      S_PS:  cmd.op = mau_pkg::OP_POW_SHIFT;
      S_DISP: if (status.action == mau_pkg::ACT_ADD || status.action == mau_pkg::ACT_SUB ||
                  status.action == mau_pkg::ACT_NEG || status.action == mau_pkg::ACT_EQU)
                cmd.op = mau_pkg::OP_SIMPLE;
      default: cmd.op = mau_pkg::OP_NONE;
    endcase
    if (state == S_QI || state == S_QS || state == S_QD) cmd.mdst = mau_pkg::MD_INV_S;
  end

  // sequencer: reduce, dispatch, iterate, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mdst <= mau_pkg::MD_RESULT;
      qmul <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (load) state <= S_RA;
        S_RA: state <= status.mod_small ? S_OUT : S_RAS;
        S_RAS: if (status.red_done) state <= S_RAF;
        S_RAF: state <= S_RB;
        S_RB: state <= S_RBS;
        S_RBS: if (status.red_done) state <= S_RBF;
        S_RBF: state <= S_DISP;
        S_DISP: begin
          unique case (status.action)
            mau_pkg::ACT_MUL: begin mdst <= mau_pkg::MD_RESULT; state <= S_MI; end
            mau_pkg::ACT_DIV, mau_pkg::ACT_INV: state <= S_II;
            mau_pkg::ACT_POW: state <= S_PI;
            default: state <= S_OUT;
          endcase
        end
        S_MI: state <= S_MS;
        S_MS: if (status.mul_done) state <= S_MD;
        S_MD: begin
          if (mdst == mau_pkg::MD_RESULT || mdst == mau_pkg::MD_DIV_RES) state <= S_OUT;
          else if (mdst == mau_pkg::MD_POW_R) begin
            mdst <= mau_pkg::MD_POW_BASE; state <= S_MI;
          end else state <= S_PS;
        end
        S_II: state <= S_PT;
        S_PT: begin
          if (qmul) state <= status.exp_zero ? S_OUT : S_PT;
          if (!qmul) state <= status.euclid_done ? S_IF : S_DS;
          if (qmul && !status.exp_zero) begin
            mdst <= status.exp_lsb ? mau_pkg::MD_POW_R : mau_pkg::MD_POW_BASE;
            state <= S_MI;
          end
        end
        S_DS: if (status.div_done) state <= S_DE;
        S_DE: state <= S_UPD;
        S_UPD: state <= S_QI;
        S_QI: state <= S_QS;
        S_QS: if (status.mul_done) state <= S_QD;
        S_QD: state <= S_PT;
        S_IF: begin
          if (status.action == mau_pkg::ACT_INV) state <= S_OUT;
          else if (status.action == mau_pkg::ACT_DIV) begin
            mdst <= mau_pkg::MD_DIV_RES; state <= S_MI;
          end else begin qmul <= 1'b1; state <= S_PT; end
        end
        S_PI: begin
          if (status.exp_neg) begin qmul <= 1'b0; state <= S_II; end
          else begin qmul <= 1'b1; state <= S_PT; end
        end
        S_PS: state <= S_PT;
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1; qmul <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/mau_checker.sv */
module mau_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second beat accepted");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");
endmodule

bind modular_arithmetic_unit_core mau_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

/* tb/tb_modular_arithmetic_unit_core.sv */
module tb_modular_arithmetic_unit_core;

  localparam int VALUE_BITS = 62;
  localparam longint unsigned CYCLE_LIMIT = 16_000_000;

  typedef struct {
    mau_pkg::action_t act;
    logic [63:0]      opa;
    logic [63:0]      opb;
  } mau_item_t;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  bad;
  } mau_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [VALUE_BITS-1:0] cfg_data;

  mau_in_if in_ch();
  mau_out_if #(.VALUE_BITS(VALUE_BITS)) out_ch();

  modular_arithmetic_unit_core #(.VALUE_BITS(VALUE_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  mau_item_t   pending_items[$];
  mau_result_t expected_results[$];
  logic [63:0] cur_modulus;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          failed;
  longint unsigned cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic logic [63:0] wrap_signed(logic [63:0] raw, logic [63:0] m);
    logic [63:0] r;
    if (!raw[63]) return raw % m;
    r = (-raw) % m;
    return (r != 0) ? m - r : 64'd0;
  endfunction

  function automatic logic [63:0] mod_sub(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] p;
    logic [127:0] mm;
    p = {64'd0, a} * {64'd0, b};
    mm = {64'd0, m};
    return 64'(p % mm);
  endfunction

  // bezout coefficient of v against m, flag set when gcd is not one
  function automatic logic [63:0] mod_inverse(logic [63:0] v, logic [63:0] m,
                                              output logic bad);
    logic [63:0] x, y, q, rem, s_old, s_cur, s_next;
    x = v;
    y = m;
    s_old = 64'd1;
    s_cur = 64'd0;
    while (y != 0) begin
      q = x / y;
      rem = x - q * y;
      s_next = mod_sub(s_old, mod_mul(q % m, s_cur, m), m);
      x = y;
      y = rem;
      s_old = s_cur;
      s_cur = s_next;
    end
    bad = (x != 64'd1);
    return s_old % m;
  endfunction

  function automatic logic [63:0] mod_power(logic [63:0] base, logic [63:0] e,
                                            logic [63:0] m);
    logic [63:0] r;
    r = 64'd1 % m;
    while (e != 0) begin
      if (e[0]) r = mod_mul(r, base, m);
      base = mod_mul(base, base, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic mau_result_t predict_result(mau_item_t it, logic [63:0] m);
    mau_result_t rsp;
    logic [63:0] a, b, s, base, e, iv;
    logic bad;
    rsp.value = '0;
    rsp.bad = 1'b0;
    bad = 1'b0;
    if (m >= 2) begin
      a = wrap_signed(it.opa, m);
      b = wrap_signed(it.opb, m);
      case (it.act)
        mau_pkg::ACT_ADD: begin
          s = a + b;
          s = (s >= m) ? s - m : s;
        end
        mau_pkg::ACT_SUB: s = mod_sub(a, b, m);
        mau_pkg::ACT_NEG: s = (a != 0) ? m - a : 64'd0;
        mau_pkg::ACT_MUL: s = mod_mul(a, b, m);
        mau_pkg::ACT_DIV: begin
          iv = mod_inverse(b, m, bad);
          s = mod_mul(a, iv, m);
        end
        mau_pkg::ACT_INV: s = mod_inverse(a, m, bad);
        mau_pkg::ACT_POW: begin
          base = a;
          e = it.opb;
          if (e[63]) begin
            base = mod_inverse(a, m, bad);
            e = -e;
          end
          s = mod_power(base, e, m);
        end
        default: s = (a == b) ? 64'd1 : 64'd0;
      endcase
      rsp.value = s[VALUE_BITS-1:0];
      rsp.bad = bad;
    end
    return rsp;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [63:0] full_random();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (v == 64'h8000_0000_0000_0000) v = 64'h8000_0000_0000_0001;
    return v;
  endfunction

  function automatic logic [63:0] pick_operand(logic [63:0] m);
    logic [63:0] v;
    case ($urandom_range(5))
      0: v = 64'($signed($urandom_range(40)) - 20);
      1, 2: v = full_random();
      3: v = m * $urandom_range(3) + 64'($signed($urandom_range(4)) - 2);
      4: v = $urandom_range(1) ? 64'h7fff_ffff_ffff_ffff : 64'h8000_0000_0000_0001;
      default: v = m - 1;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] pick_exponent();
    if ($urandom_range(3) == 0) return full_random();
    return 64'($signed($urandom_range(2000)) - 1000);
  endfunction

  task automatic queue_item(mau_pkg::action_t act, logic [63:0] opa, logic [63:0] opb);
    mau_item_t it;
    it.act = act;
    it.opa = opa;
    it.opb = opb;
    pending_items.push_back(it);
  endtask

  task automatic queue_random(int n);
    mau_pkg::action_t act;
    repeat (n) begin
      act = mau_pkg::action_t'($urandom_range(7));
      queue_item(act, pick_operand(cur_modulus),
                 (act == mau_pkg::ACT_POW) ? pick_exponent() : pick_operand(cur_modulus));
    end
  endtask

  // hold until every beat has gone in and come back
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_modulus(logic [63:0] m);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m[VALUE_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_modulus = {2'b00, m[VALUE_BITS-1:0]};
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    mau_item_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= it.act;
        in_ch.operand_a <= it.opa;
        in_ch.operand_b <= it.opb;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    mau_item_t it;
    mau_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      // predict on each accepted input beat
      if (in_ch.valid && in_ch.ready) begin
        it.act = mau_pkg::action_t'(in_ch.action);
        it.opa = in_ch.operand_a;
        it.opb = in_ch.operand_b;
        expected_results.push_back(predict_result(it, cur_modulus));
      end
      // compare each accepted output beat
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: result=%0d", out_ch.result);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.result !== want.value) begin
            $error("result mismatch: expected %0d actual %0d", want.value, out_ch.result);
            failed = 1'b1;
          end
          if (out_ch.not_invertible !== want.bad) begin
            $error("not_invertible mismatch: expected %0d actual %0d",
                   want.bad, out_ch.not_invertible);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("modular_arithmetic_unit_core regression: fail");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    logic [63:0] moduli[8];
    int counts[8];
    failed = 1'b0;
    cycle_count = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = mau_pkg::ACT_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_modulus = mau_pkg::RESET_MODULUS;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed beats under the reset modulus
    queue_item(mau_pkg::ACT_ADD, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
    queue_item(mau_pkg::ACT_ADD, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
    queue_item(mau_pkg::ACT_SUB, 64'd0, 64'd1);
    queue_item(mau_pkg::ACT_SUB, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0001);
    queue_item(mau_pkg::ACT_NEG, 64'd0, full_random());
    queue_item(mau_pkg::ACT_NEG, -64'd5, full_random());
    queue_item(mau_pkg::ACT_MUL, cur_modulus - 1, cur_modulus - 1);
    queue_item(mau_pkg::ACT_MUL, 64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_ffff);
    queue_item(mau_pkg::ACT_DIV, 64'd7, 64'd3);
    queue_item(mau_pkg::ACT_DIV, 64'd7, cur_modulus);
    queue_item(mau_pkg::ACT_INV, 64'd0, full_random());
    queue_item(mau_pkg::ACT_INV, 64'd1, full_random());
    queue_item(mau_pkg::ACT_INV, -64'd1, 64'd0);
    queue_item(mau_pkg::ACT_POW, 64'd0, 64'd0);
    queue_item(mau_pkg::ACT_POW, 64'd3, 64'h7fff_ffff_ffff_ffff);
    queue_item(mau_pkg::ACT_POW, 64'd3, 64'h8000_0000_0000_0001);
    queue_item(mau_pkg::ACT_POW, 64'd0, -64'd1);
    queue_item(mau_pkg::ACT_POW, cur_modulus - 1, cur_modulus - 2);
    queue_item(mau_pkg::ACT_EQU, -64'd1, cur_modulus - 1);
    queue_item(mau_pkg::ACT_EQU, 64'd4, 64'd5);
    wait_drained();

    // modulus settings, with the idle mix rotating per setting
    moduli = '{64'd2305843009213693951, 64'd2, 64'd12, 64'h3fff_ffff_ffff_ffff,
               64'd1, 64'd0, 64'd1000003, 64'd998244353};
    counts = '{16, 8, 10, 14, 4, 4, 12, 14};
    for (int p = 0; p < 8; p++) begin
      write_modulus(moduli[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      queue_random(counts[p]);
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (!failed) begin
      $display("modular_arithmetic_unit_core regression: pass");
    end else begin
      $display("modular_arithmetic_unit_core regression: fail");
    end
    $finish;
  end

endmodule

/* modular_arithmetic_unit_core.f */
hw/rtl/mau_pkg.sv
hw/rtl/mau_if.sv
hw/rtl/mau_datapath.sv
hw/rtl/mau_control.sv
hw/rtl/modular_arithmetic_unit_core.sv
hw/rtl/mau_checker.sv
tb/tb_modular_arithmetic_unit_core.sv
